/* rtl/tmrp_pkg.sv */
// ----------------------------------------------------------------------------
// tmrp_pkg
// Types and codes shared by the tile map row-run patch decoder.
// ----------------------------------------------------------------------------
package tmrp_pkg;

    // Parse position within the patch byte stream (one-hot).
    typedef enum logic [6:0] {
        PH_COUNT = 7'b0000001,
        PH_ROW   = 7'b0000010,
        PH_COL   = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_LO    = 7'b0010000,
        PH_HI    = 7'b0100000,
        PH_DONE  = 7'b1000000
    } phase_t;

    // Sequencer: parsing input words, priming the buffer read, emitting a run.
    typedef enum logic [2:0] {
        CTRL_PARSE = 3'b001,
        CTRL_LOAD  = 3'b010,
        CTRL_EMIT  = 3'b100
    } ctrl_t;

    // Width of the cell index carried on the result channel.
    localparam int CELL_W = 9;

endpackage

/* rtl/tmrp_ram.sv */
// ----------------------------------------------------------------------------
// tmrp_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tmrp_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
)
(
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH < 2 ? 1 : $clog2(DEPTH))-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH < 2 ? 1 : $clog2(DEPTH))-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port: the data register holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tilemap_row_run_patch_decoder.sv */
// ----------------------------------------------------------------------------
// tilemap_row_run_patch_decoder
// Parses a row-run patch stream and emits name-table writes, one per word.
// ----------------------------------------------------------------------------
// Throughput: one patch word per cycle while no run completes and the result
// side is not stalled. The word that completes a run of L tiles is followed
// by a stretch in which input is stalled: the LOAD state primes the run buffer
// read, then one write word leaves per cycle while the result side takes it,
// paced by the single buffer read port. A final word with no writes has its
// result loaded straight into the result register.
// Reset clears the parser and sequencer; the run buffer is not cleared.
module tilemap_row_run_patch_decoder
    import tmrp_pkg::*;
#(
    parameter int MAP_ROWS = 18,
    parameter int MAP_COLS = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              patch_valid,
    output logic              patch_stall,
    input  logic [7:0]        patch_byte,
    input  logic              final_byte,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              write_valid,
    output logic [CELL_W-1:0] cell_index,
    output logic [15:0]       tile_word,
    output logic              last_of_run,
    output logic              patch_done,
    output logic              patch_ok
);

    localparam int CNT_W  = $clog2(MAP_COLS + 1);
    localparam int ADDR_W = (MAP_COLS < 2) ? 1 : $clog2(MAP_COLS);

    // Control state.
    ctrl_t             ctrl_reg, ctrl_next;
    phase_t            phase_reg, phase_next;
    logic              rejected_flag_reg, rejected_flag_next;
    logic [7:0]        runs_remaining_reg, runs_remaining_next;
    logic [CNT_W-1:0]  words_gathered_reg, words_gathered_next;
    logic [CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              fin_pend_reg, fin_pend_next;
    logic              ok_pend_reg, ok_pend_next;
    logic              out_valid_reg, out_valid_next;

    // Run header and result payload.
    logic [7:0]        run_row_reg, run_row_next;
    logic [7:0]        run_column_reg, run_column_next;
    logic [7:0]        run_length_reg, run_length_next;
    logic [7:0]        low_byte_hold_reg, low_byte_hold_next;
    logic [CELL_W-1:0] run_base_reg, run_base_next;
    logic              out_wv_reg;
    logic [CELL_W-1:0] out_cell_reg;
    logic [15:0]       out_word_reg;
    logic              out_last_reg;
    logic              out_done_reg;
    logic              out_ok_reg;

    // Combinational helpers.
    logic              patch_accept;
    logic              load_ok;
    logic              run_complete;
    logic [8:0]        wg_plus;
    logic [CNT_W-1:0]  emit_cnt_plus;
    logic              emit_last;
    logic              out_load;
    logic              out_wv;
    logic [CELL_W-1:0] out_cell;
    logic [15:0]       out_word;
    logic              out_last;
    logic              out_done;
    logic              out_ok;

    // Run buffer ports.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [15:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [15:0]       ram_rd_data;

    tmrp_ram
    #(
        .WIDTH (16),
        .DEPTH (MAP_COLS)
    )
    u_run_buf
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Handshake: the result register may load when empty or being drained.
    assign load_ok       = !out_valid_reg || !result_stall;
    assign patch_stall   = (ctrl_reg != CTRL_PARSE) || !load_ok;
    assign patch_accept  = patch_valid && !patch_stall;
    assign wg_plus       = 9'(words_gathered_reg) + 9'd1;
    assign emit_cnt_plus = emit_cnt_reg + 1'b1;
    assign emit_last     = (9'(emit_cnt_plus) == {1'b0, run_length_reg});

    // Parser, run buffer access and emission sequencer.
    always_comb
    begin
        ctrl_next           = ctrl_reg;
        phase_next          = phase_reg;
        rejected_flag_next  = rejected_flag_reg;
        runs_remaining_next = runs_remaining_reg;
        words_gathered_next = words_gathered_reg;
        emit_cnt_next       = emit_cnt_reg;
        fin_pend_next       = fin_pend_reg;
        ok_pend_next        = ok_pend_reg;
        run_row_next        = run_row_reg;
        run_column_next     = run_column_reg;
        run_length_next     = run_length_reg;
        low_byte_hold_next  = low_byte_hold_reg;
        run_base_next       = run_base_reg;
        run_complete        = 1'b0;
        ram_wr_en           = 1'b0;
        ram_wr_addr         = words_gathered_reg[ADDR_W-1:0];
        ram_wr_data         = {patch_byte, low_byte_hold_reg};
        ram_rd_en           = 1'b0;
        ram_rd_addr         = '0;
        out_load            = 1'b0;
        out_wv              = 1'b0;
        out_cell            = '0;
        out_word            = '0;
        out_last            = 1'b0;
        out_done            = 1'b0;
        out_ok              = 1'b0;

        unique case (ctrl_reg)
            CTRL_PARSE:
            begin
                if (patch_accept)
                begin
                    if (!rejected_flag_reg)
                    begin
                        unique case (phase_reg)
                            PH_COUNT:
                            begin
                                runs_remaining_next = patch_byte;
                                phase_next = (patch_byte != 8'd0) ? PH_ROW : PH_DONE;
                            end
                            PH_ROW:
                            begin
                                run_row_next = patch_byte;
                                phase_next   = PH_COL;
                            end
                            PH_COL:
                            begin
                                run_column_next = patch_byte;
                                phase_next      = PH_LEN;
                            end
                            PH_LEN:
                            begin
                                run_length_next = patch_byte;
                                run_base_next   = CELL_W'(16'(run_row_reg) * 16'(MAP_COLS)
                                                          + 16'(run_column_reg));
                                if (({1'b0, run_row_reg} >= 9'(MAP_ROWS)) ||
                                    ({1'b0, run_column_reg} >= 9'(MAP_COLS)) ||
                                    (patch_byte == 8'd0) ||
                                    ((9'(run_column_reg) + 9'(patch_byte)) > 9'(MAP_COLS)))
                                begin
                                    rejected_flag_next = 1'b1;
                                end
                                else
                                begin
                                    words_gathered_next = '0;
                                    phase_next          = PH_LO;
                                end
                            end
                            PH_LO:
                            begin
                                low_byte_hold_next = patch_byte;
                                phase_next         = PH_HI;
                            end
                            PH_HI:
                            begin
                                ram_wr_en           = 1'b1;
                                words_gathered_next = words_gathered_reg + 1'b1;
                                if (wg_plus >= {1'b0, run_length_reg})
                                begin
                                    run_complete        = 1'b1;
                                    runs_remaining_next = runs_remaining_reg - 8'd1;
                                    phase_next = (runs_remaining_next != 8'd0) ? PH_ROW
                                                                                : PH_DONE;
                                    ctrl_next     = CTRL_LOAD;
                                    fin_pend_next = final_byte;
                                    ok_pend_next  = final_byte && (runs_remaining_next == 8'd0);
                                end
                                else
                                begin
                                    phase_next = PH_LO;
                                end
                            end
                            default:
                            begin
                                // Any word after the last run spoils the patch.
                                rejected_flag_next = 1'b1;
                            end
                        endcase
                    end

                    // Final word: report unless a run emission carries the status.
                    if (final_byte)
                    begin
                        if (!run_complete)
                        begin
                            out_load = 1'b1;
                            out_last = 1'b1;
                            out_done = 1'b1;
                            out_ok   = !rejected_flag_next && (phase_next == PH_DONE);
                        end
                        phase_next          = PH_COUNT;
                        rejected_flag_next  = 1'b0;
                        runs_remaining_next = '0;
                    end
                end
            end
            CTRL_LOAD:
            begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = '0;
                emit_cnt_next = '0;
                ctrl_next     = CTRL_EMIT;
            end
            CTRL_EMIT:
            begin
                if (load_ok)
                begin
                    out_load = 1'b1;
                    out_wv   = 1'b1;
                    out_cell = run_base_reg + CELL_W'(emit_cnt_reg);
                    out_word = ram_rd_data;
                    if (emit_last)
                    begin
                        out_last  = 1'b1;
                        out_done  = fin_pend_reg;
                        out_ok    = ok_pend_reg;
                        ctrl_next = CTRL_PARSE;
                    end
                    else
                    begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = emit_cnt_plus[ADDR_W-1:0];
                        emit_cnt_next = emit_cnt_plus;
                    end
                end
            end
            default:
            begin
                ctrl_next = CTRL_PARSE;
            end
        endcase
    end

    // Result register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and parse registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg           <= CTRL_PARSE;
            phase_reg          <= PH_COUNT;
            rejected_flag_reg  <= 1'b0;
            runs_remaining_reg <= '0;
            words_gathered_reg <= '0;
            emit_cnt_reg       <= '0;
            fin_pend_reg       <= 1'b0;
            ok_pend_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
            run_row_reg        <= '0;
            run_column_reg     <= '0;
            run_length_reg     <= '0;
            low_byte_hold_reg  <= '0;
        end
        else
        begin
            ctrl_reg           <= ctrl_next;
            phase_reg          <= phase_next;
            rejected_flag_reg  <= rejected_flag_next;
            runs_remaining_reg <= runs_remaining_next;
            words_gathered_reg <= words_gathered_next;
            emit_cnt_reg       <= emit_cnt_next;
            fin_pend_reg       <= fin_pend_next;
            ok_pend_reg        <= ok_pend_next;
            out_valid_reg      <= out_valid_next;
            run_row_reg        <= run_row_next;
            run_column_reg     <= run_column_next;
            run_length_reg     <= run_length_next;
            low_byte_hold_reg  <= low_byte_hold_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        run_base_reg <= run_base_next;
        if (out_load)
        begin
            out_wv_reg   <= out_wv;
            out_cell_reg <= out_cell;
            out_word_reg <= out_word;
            out_last_reg <= out_last;
            out_done_reg <= out_done;
            out_ok_reg   <= out_ok;
        end
    end

    assign result_valid = out_valid_reg;
    assign write_valid  = out_wv_reg;
    assign cell_index   = out_cell_reg;
    assign tile_word    = out_word_reg;
    assign last_of_run  = out_last_reg;
    assign patch_done   = out_done_reg;
    assign patch_ok     = out_ok_reg;

    // A word that completes a run always starts the buffer read-out.
    a_complete_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (patch_accept && run_complete) |=> (ctrl_reg == CTRL_LOAD))
        else $error("completed run did not start emission");

    // The emission counter never passes the run length.
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg == CTRL_EMIT) |-> (9'(emit_cnt_reg) < {1'b0, run_length_reg}))
        else $error("emission index beyond run length");

    // While gathering, the word count stays below the accepted run length.
    a_gather_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!rejected_flag_reg && ((phase_reg == PH_LO) || (phase_reg == PH_HI)))
        |-> (9'(words_gathered_reg) < {1'b0, run_length_reg}))
        else $error("gathered word count beyond run length");

    // Status flags only travel on the closing result of a patch word.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (patch_done || patch_ok)) |-> (last_of_run && patch_done))
        else $error("patch status on a result that does not close its word");

    // A write is only ever presented while the sequencer is draining a run.
    a_write_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_wv) |-> (ctrl_reg == CTRL_EMIT))
        else $error("write result loaded outside emission");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tile map row-run patch decoder.
// A short table of hand-built patches is streamed in first, followed by random
// patches, most of them well formed. Every result word is compared field by
// field with the bench's behavioural decoder or typed status, with random gaps
// on both channels, one long result hold-off and one full drain of the sender.
// ----------------------------------------------------------------------------
module tb_top
    import tmrp_pkg::*;
();

    localparam int MAP_ROWS     = 18;
    localparam int MAP_COLS     = 20;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_WORDS = 120;
    localparam int IDLE_PERCENT = 27;
    localparam int HOLD_START   = 30;
    localparam int HOLD_CYCLES  = 160;
    localparam int STEADY_FROM  = 60;
    localparam int STEADY_TO    = 95;
    localparam int DRAIN_AT     = 110;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int TABLE_ROWS   = 28;

    // One row of the directed table: a patch word, and where the outcome is
    // obvious, the done status typed in by hand.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       typed;
        logic       typed_ok;
    } table_row_t;

    // One result word as it leaves the decoder.
    typedef struct packed {
        logic              write_valid;
        logic [CELL_W-1:0] cell_index;
        logic [15:0]       tile_word;
        logic              last_of_run;
        logic              patch_done;
        logic              patch_ok;
    } write_word_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              patch_valid  = 1'b0;
    logic              patch_stall;
    logic [7:0]        patch_byte   = 8'h00;
    logic              final_byte   = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              write_valid;
    logic [CELL_W-1:0] cell_index;
    logic [15:0]       tile_word;
    logic              last_of_run;
    logic              patch_done;
    logic              patch_ok;

    // Bench-side companions of the patch word being offered.
    logic row_typed     = 1'b0;
    logic row_typed_ok  = 1'b0;
    logic steady_window = 1'b0;
    logic hold_results  = 1'b0;

    int random_words_sent = 0;
    int write_errors      = 0;
    int cycle_count       = 0;

    // Behavioural decoder state.
    phase_t      dec_phase;
    logic [7:0]  dec_runs_left;
    logic [7:0]  dec_row;
    logic [7:0]  dec_col;
    logic [7:0]  dec_len;
    logic [7:0]  dec_low;
    int unsigned dec_words;
    logic        dec_rejected;
    logic [15:0] dec_run_words [MAP_COLS];

    write_word_t emitted_now [$];
    write_word_t expected_writes [$];

    table_row_t directed_rows [TABLE_ROWS] = '{
        // Zero run count ended at once: ok.
        '{8'd0,   1'b1, 1'b1, 1'b1},
        // Zero run count followed by a stray byte: not ok.
        '{8'd0,   1'b0, 1'b0, 1'b0},
        '{8'h80,  1'b1, 1'b1, 1'b0},
        // One run at the last cell with an all-ones tile; the final word
        // completes the run, so done rides on the write.
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'd17,  1'b0, 1'b0, 1'b0},
        '{8'd19,  1'b0, 1'b0, 1'b0},
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'hFF,  1'b0, 1'b0, 1'b0},
        '{8'hFF,  1'b1, 1'b0, 1'b0},
        // Row out of range; the trailing byte is ignored.
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'd18,  1'b0, 1'b0, 1'b0},
        '{8'd0,   1'b0, 1'b0, 1'b0},
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'h55,  1'b1, 1'b1, 1'b0},
        // Column out of range.
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'd0,   1'b0, 1'b0, 1'b0},
        '{8'd20,  1'b0, 1'b0, 1'b0},
        '{8'd1,   1'b1, 1'b1, 1'b0},
        // Zero run length.
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'd0,   1'b0, 1'b0, 1'b0},
        '{8'd0,   1'b0, 1'b0, 1'b0},
        '{8'd0,   1'b1, 1'b1, 1'b0},
        // Run passes the end of the row.
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'd0,   1'b0, 1'b0, 1'b0},
        '{8'd19,  1'b0, 1'b0, 1'b0},
        '{8'd2,   1'b1, 1'b1, 1'b0},
        // Stream ends inside a run header.
        '{8'd1,   1'b0, 1'b0, 1'b0},
        '{8'd0,   1'b1, 1'b1, 1'b0}
    };

    tilemap_row_run_patch_decoder #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .patch_valid  (patch_valid),
        .patch_stall  (patch_stall),
        .patch_byte   (patch_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .write_valid  (write_valid),
        .cell_index   (cell_index),
        .tile_word    (tile_word),
        .last_of_run  (last_of_run),
        .patch_done   (patch_done),
        .patch_ok     (patch_ok)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Return the parser to the start of a patch.
    task automatic restart_patch();
        dec_phase     = PH_COUNT;
        dec_runs_left = 8'd0;
        dec_row       = 8'd0;
        dec_col       = 8'd0;
        dec_len       = 8'd0;
        dec_low       = 8'd0;
        dec_words     = 0;
        dec_rejected  = 1'b0;
    endtask

    // Decode one patch word and leave the result words it causes in
    // emitted_now.
    task automatic decode_patch_word(input logic [7:0] data, input logic fin);
        int unsigned base;
        logic        ok;
        emitted_now = {};
        if (!dec_rejected)
        begin
            case (dec_phase)
                PH_COUNT:
                begin
                    dec_runs_left = data;
                    dec_phase = (data != 8'd0) ? PH_ROW : PH_DONE;
                end
                PH_ROW:
                begin
                    dec_row   = data;
                    dec_phase = PH_COL;
                end
                PH_COL:
                begin
                    dec_col   = data;
                    dec_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    dec_len = data;
                    if (dec_row >= MAP_ROWS || dec_col >= MAP_COLS || dec_len == 8'd0 ||
                        int'(dec_col) + int'(dec_len) > MAP_COLS)
                        dec_rejected = 1'b1;
                    else
                    begin
                        dec_words = 0;
                        dec_phase = PH_LO;
                    end
                end
                PH_LO:
                begin
                    dec_low   = data;
                    dec_phase = PH_HI;
                end
                PH_HI:
                begin
                    if (dec_words < MAP_COLS)
                        dec_run_words[dec_words] = {data, dec_low};
                    dec_words++;
                    // The run is complete: write it out cell by cell.
                    if (dec_words >= dec_len)
                    begin
                        base = dec_row * MAP_COLS + dec_col;
                        for (int c = 0; c < dec_len && c < MAP_COLS; c++)
                            emitted_now.push_back(write_word_t'{1'b1, CELL_W'(base + c),
                                dec_run_words[c], 1'b0, 1'b0, 1'b0});
                        dec_runs_left = dec_runs_left - 8'd1;
                        dec_phase = (dec_runs_left != 8'd0) ? PH_ROW : PH_DONE;
                    end
                    else
                        dec_phase = PH_LO;
                end
                default:
                    dec_rejected = 1'b1;
            endcase
        end

        // The final word always reports status, on a bare word if nothing
        // was written.
        if (fin)
        begin
            ok = !dec_rejected && dec_phase == PH_DONE;
            if (emitted_now.size() == 0)
                emitted_now.push_back('0);
            emitted_now[emitted_now.size() - 1].patch_done = 1'b1;
            emitted_now[emitted_now.size() - 1].patch_ok   = ok;
            restart_patch();
        end
        if (emitted_now.size() != 0)
            emitted_now[emitted_now.size() - 1].last_of_run = 1'b1;
    endtask

    // Present one patch word, with random idle cycles ahead of it, and wait
    // until it is taken.
    task automatic offer_patch_word(input logic [7:0] data, input logic fin,
                                    input logic typed, input logic typed_ok);
        while (!steady_window && $urandom_range(99) < IDLE_PERCENT)
        begin
            patch_valid <= 1'b0;
            @(posedge clk);
        end
        patch_valid  <= 1'b1;
        patch_byte   <= data;
        final_byte   <= fin;
        row_typed    <= typed;
        row_typed_ok <= typed_ok;
        @(posedge clk);
        while (patch_stall)
            @(posedge clk);
    endtask

    // Build one random patch, mostly well formed, and stream it in.
    task automatic send_random_patch();
        logic [7:0] stream [$];
        int         heads [$];
        int         shape;
        int         runs;
        int         len;
        int         col;
        int         h;
        int         cut;
        shape = $urandom_range(99);
        runs  = (shape < 4) ? 0 : $urandom_range(1, 2);
        stream.push_back(8'(runs));
        for (int r = 0; r < runs; r++)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(5, MAP_COLS) : $urandom_range(1, 3);
            col = $urandom_range(MAP_COLS - len);
            heads.push_back(stream.size());
            stream.push_back(8'($urandom_range(MAP_ROWS - 1)));
            stream.push_back(8'(col));
            stream.push_back(8'(len));
            repeat (2 * len)
                stream.push_back(8'($urandom_range(255)));
        end

        // Damage the well-formed patch in one of several ways, or leave it intact.
        h = (runs != 0) ? heads[$urandom_range(runs - 1)] : 0;
        if (shape < 2)
            stream.push_back(8'($urandom_range(255)));
        else if (shape < 60)
            ;
        else if (shape < 66)
            stream[h] = 8'($urandom_range(MAP_ROWS, 255));
        else if (shape < 72)
            stream[h + 1] = 8'($urandom_range(MAP_COLS, 255));
        else if (shape < 77)
            stream[h + 2] = 8'd0;
        else if (shape < 82)
            stream[h + 2] = 8'($urandom_range(MAP_COLS - stream[h + 1] + 1, 255));
        else if (shape < 90)
        begin
            cut    = $urandom_range(1, stream.size() - 1);
            stream = stream[0:cut - 1];
        end
        else if (shape < 95)
        begin
            repeat ($urandom_range(1, 3))
                stream.push_back(8'($urandom_range(255)));
        end
        else
        begin
            stream = {};
            repeat ($urandom_range(1, 6))
                stream.push_back(8'($urandom_range(255)));
        end

        foreach (stream[i])
        begin
            offer_patch_word(stream[i], i == stream.size() - 1, 1'b0, 1'b0);
            random_words_sent++;
        end
    endtask

    // Predict the result words of every accepted patch word.
    always @(posedge clk)
    begin : track_patch_words
        if (rst_n && patch_valid && !patch_stall)
        begin
            decode_patch_word(patch_byte, final_byte);
            if (row_typed)
                expected_writes.push_back(write_word_t'{1'b0, CELL_W'(0), 16'h0000,
                                                        1'b1, 1'b1, row_typed_ok});
            else
                foreach (emitted_now[k])
                    expected_writes.push_back(emitted_now[k]);
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : check_write_words
        write_word_t got;
        write_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{write_valid, cell_index, tile_word, last_of_run, patch_done, patch_ok};
            if (expected_writes.size() == 0)
            begin
                write_errors++;
                if (write_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result word: valid %0b cell %0d tile %h",
                             $time, got.write_valid, got.cell_index, got.tile_word,
                             " last %0b done %0b ok %0b",
                             got.last_of_run, got.patch_done, got.patch_ok);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (got.write_valid !== want.write_valid || got.cell_index !== want.cell_index ||
                    got.tile_word !== want.tile_word || got.last_of_run !== want.last_of_run ||
                    got.patch_done !== want.patch_done || got.patch_ok !== want.patch_ok)
                begin
                    write_errors++;
                    if (write_errors <= MAX_REPORTS)
                    begin
                        $display("%0t: result word mismatch", $time);
                        $display("  expected valid %0b cell %0d tile %h last %0b done %0b ok %0b",
                                 want.write_valid, want.cell_index, want.tile_word,
                                 want.last_of_run, want.patch_done, want.patch_ok);
                        $display("  actual   valid %0b cell %0d tile %h last %0b done %0b ok %0b",
                                 got.write_valid, got.cell_index, got.tile_word,
                                 got.last_of_run, got.patch_done, got.patch_ok);
                    end
                end
            end
        end
    end

    // Result side back-pressure: random, off in the steady stretch, solid
    // during the hold-off.
    always @(posedge clk)
    begin : drive_result_stall
        if (hold_results)
            result_stall <= 1'b1;
        else if (steady_window)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end

    // One long hold-off on the result side so that the decoder backs up and
    // stalls its input while patch words keep coming.
    initial
    begin : hold_off_results
        wait (random_words_sent >= HOLD_START);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_results <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset, directed table, random patches, then drain and report.
    initial
    begin : run_patches
        bit drained_once;
        drained_once = 1'b0;
        restart_patch();
        foreach (dec_run_words[i])
            dec_run_words[i] = 16'h0000;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_patch_word(directed_rows[i].data, directed_rows[i].fin,
                             directed_rows[i].typed, directed_rows[i].typed_ok);

        while (random_words_sent < RANDOM_WORDS || !drained_once)
        begin
            // Once, let the decoder run completely dry before carrying on.
            if (!drained_once && random_words_sent >= DRAIN_AT)
            begin
                drained_once = 1'b1;
                patch_valid <= 1'b0;
                @(posedge clk);
                while (expected_writes.size() != 0)
                    @(posedge clk);
            end
            steady_window <= (random_words_sent >= STEADY_FROM &&
                              random_words_sent < STEADY_TO);
            send_random_patch();
        end
        patch_valid   <= 1'b0;
        steady_window <= 1'b0;

        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (write_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* tilemap_row_run_patch_decoder.f */
rtl/tmrp_pkg.sv
rtl/tmrp_ram.sv
rtl/tilemap_row_run_patch_decoder.sv
dv/tb_top.sv
